[rtl/core/tcbdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbdp_pkg
// Shared types and constants for the ternary codebook block dot product core.
// ----------------------------------------------------------------------------
package tcbdp_pkg;

	// working significand: bit 48 is the unit position, bit 49 catches carries
	localparam int SIG_W = 50;
	localparam int EXP_W = 11;

	typedef logic [SIG_W-1:0]        fsig_t;
	typedef logic signed [EXP_W-1:0] fexp_t;
	typedef logic [1:0]              fop_t;

	localparam fop_t FOP_CVH = 2'd0;   // half bits to single
	localparam fop_t FOP_CVI = 2'd1;   // signed integer to single
	localparam fop_t FOP_MUL = 2'd2;
	localparam fop_t FOP_ADD = 2'd3;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

	typedef struct packed {
		logic start;
		fop_t op;
	} fpu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fpu_stat_t;

endpackage

[rtl/core/tcbdp_fpu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbdp_fpu
// Shared single-precision unit: half/int conversion, multiply and add with
// round to nearest even; normalization runs one bit per cycle.
// ----------------------------------------------------------------------------
module tcbdp_fpu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcbdp_pkg::fpu_req_t  req,
	input  logic [31:0]          a,
	input  logic [31:0]          b,
	output tcbdp_pkg::fpu_stat_t stat,
	output logic [31:0]          result
);
	import tcbdp_pkg::*;

	localparam logic [1:0] F_IDLE   = 2'd0;
	localparam logic [1:0] F_NORM   = 2'd1;
	localparam logic [1:0] F_DENORM = 2'd2;
	localparam logic [1:0] F_ROUND  = 2'd3;

	logic [1:0]  state_q;
	fsig_t       sig_q;
	fexp_t       exp_q;
	logic        sign_q;
	logic        done_q;
	logic [31:0] result_q;

	// operand unpack
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] a_m, b_m;
	logic [7:0]  a_e, b_e;
	// load result
	logic        ld_special;
	logic [31:0] ld_bits;
	logic        ld_sign;
	fexp_t       ld_exp;
	fsig_t       ld_sig;
	// adder alignment
	logic        a_big;
	logic [7:0]  e_big, e_small, e_diff;
	fsig_t       big_sig, small_sig, small_sh, small_al;
	logic        small_st, s_big, s_small;
	logic [31:0] mag;
	logic [47:0] prod;
	// rounding
	logic [23:0] rm;
	logic        rg, rs, rinc;
	logic [31:0] rpack;

	always_comb begin
		a_e    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		b_e    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		a_m    = {a[30:23] != 8'd0, a[22:0]};
		b_m    = {b[30:23] != 8'd0, b[22:0]};
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);

		a_big    = (a[30:0] >= b[30:0]);
		e_big    = a_big ? a_e : b_e;
		e_small  = a_big ? b_e : a_e;
		s_big    = a_big ? a[31] : b[31];
		s_small  = a_big ? b[31] : a[31];
		e_diff   = e_big - e_small;
		big_sig  = {1'b0, (a_big ? a_m : b_m), 25'd0};
		small_sig = {1'b0, (a_big ? b_m : a_m), 25'd0};
		if (e_diff >= 8'(SIG_W)) begin
			small_sh = '0;
			small_st = |small_sig;
		end else begin
			small_sh = small_sig >> e_diff;
			small_st = |(small_sig & ~({SIG_W{1'b1}} << e_diff));
		end
		small_al = small_sh | fsig_t'(small_st);

		prod = a_m * b_m;
		mag  = a[31] ? (32'd0 - a) : a;

		ld_special = 1'b0;
		ld_bits    = '0;
		ld_sign    = 1'b0;
		ld_exp     = '0;
		ld_sig     = '0;
		unique case (req.op)
			FOP_CVH: begin
				ld_sign = a[15];
				if (a[14:10] == 5'h1F) begin
					ld_special = 1'b1;
					ld_bits    = {a[15], 8'hFF, a[9:0], 13'd0};
				end else if (a[14:10] == 5'd0) begin
					ld_sig = fsig_t'(a[9:0]);
					ld_exp = fexp_t'(151);
				end else begin
					ld_sig = fsig_t'({1'b1, a[9:0]});
					ld_exp = fexp_t'({6'd0, a[14:10]}) + fexp_t'(150);
				end
			end
			FOP_CVI: begin
				ld_sign = a[31];
				ld_sig  = fsig_t'(mag);
				ld_exp  = fexp_t'(175);
			end
			FOP_MUL: begin
				ld_sign = a[31] ^ b[31];
				ld_sig  = {prod, 2'b00};
				ld_exp  = fexp_t'({3'd0, a_e}) + fexp_t'({3'd0, b_e}) - fexp_t'(127);
				if (a_nan) begin
					ld_special = 1'b1;
					ld_bits    = a | QUIET_BIT;
				end else if (b_nan) begin
					ld_special = 1'b1;
					ld_bits    = b | QUIET_BIT;
				end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
					ld_special = 1'b1;
					ld_bits    = QNAN_DEFAULT;
				end else if (a_inf || b_inf) begin
					ld_special = 1'b1;
					ld_bits    = {a[31] ^ b[31], 8'hFF, 23'd0};
				end
			end
			FOP_ADD: begin
				ld_exp = fexp_t'({3'd0, e_big});
				if (s_big == s_small) ld_sig = big_sig + small_al;
				else ld_sig = big_sig - small_al;
				ld_sign = (ld_sig == '0) ? (a[31] & b[31]) : s_big;
				if (a_nan) begin
					ld_special = 1'b1;
					ld_bits    = a | QUIET_BIT;
				end else if (b_nan) begin
					ld_special = 1'b1;
					ld_bits    = b | QUIET_BIT;
				end else if (a_inf && b_inf && (a[31] != b[31])) begin
					ld_special = 1'b1;
					ld_bits    = QNAN_DEFAULT;
				end else if (a_inf) begin
					ld_special = 1'b1;
					ld_bits    = a;
				end else if (b_inf) begin
					ld_special = 1'b1;
					ld_bits    = b;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rm    = sig_q[48:25];
		rg    = sig_q[24];
		rs    = |sig_q[23:0];
		rinc  = rg & (rs | rm[0]);
		rpack = {1'b0, 8'(exp_q - fexp_t'(1)), 23'd0} + {8'd0, rm} + 32'(rinc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						if (ld_special) begin
							result_q <= ld_bits;
							done_q   <= 1'b1;
						end else begin
							sig_q   <= ld_sig;
							exp_q   <= ld_exp;
							sign_q  <= ld_sign;
							state_q <= F_NORM;
						end
					end
				end
				F_NORM: begin
					if (sig_q[SIG_W-1]) begin
						sig_q <= (sig_q >> 1) | fsig_t'(sig_q[0]);
						exp_q <= exp_q + fexp_t'(1);
					end else if (sig_q == '0) begin
						exp_q   <= fexp_t'(1);
						state_q <= F_ROUND;
					end else if (!sig_q[SIG_W-2] && (exp_q > fexp_t'(1))) begin
						sig_q <= sig_q << 1;
						exp_q <= exp_q - fexp_t'(1);
					end else begin
						state_q <= F_DENORM;
					end
				end
				F_DENORM: begin
					if (exp_q < fexp_t'(-60)) begin
						// far below the smallest subnormal: only a sticky bit is left
						sig_q <= fsig_t'(|sig_q);
						exp_q <= fexp_t'(1);
					end else if (exp_q < fexp_t'(1)) begin
						sig_q <= (sig_q >> 1) | fsig_t'(sig_q[0]);
						exp_q <= exp_q + fexp_t'(1);
					end else begin
						state_q <= F_ROUND;
					end
				end
				F_ROUND: begin
					if (exp_q > fexp_t'(254)) result_q <= {sign_q, 8'hFF, 23'd0};
					else result_q <= {sign_q, rpack[30:0]};
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != F_IDLE);
	assign stat.done = done_q;
	assign result    = result_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !stat.busy) else $error("fpu start while busy");
	a_norm_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_NORM) |-> $past(state_q == F_NORM || state_q == F_IDLE))
		else $error("fpu state order broken");
	a_round_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_ROUND) |=> done_q) else $error("fpu round without done");

endmodule

[rtl/core/ternary_codebook_block_dot_product_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_codebook_block_dot_product_core
// Ternary codebook int8 group dot product with single-precision row fold.
// ----------------------------------------------------------------------------
// Sequence: an ordinary group is accepted, then its lanes go one per cycle
//   through the shared saturating adder.
// A block end adds five passes through the shared float unit, each longer
//   the further the significand must be shifted; a row end adds an emit
//   step, which waits while the previous result is still held.
// Throughput: one group at a time; next request is taken once the block is idle.
// Reset: arst_n clears the codebook, block sum, row accumulator and output valid.
module ternary_codebook_block_dot_product_core #(
	parameter int BLOCK_VALUES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [4:0] group_code, [12:5] act_lane0, [20:13] act_lane1,
	// [28:21] act_lane2, [36:29] act_lane3, [52:37] weight_scale_half,
	// [84:53] act_scale_single, [87:85] zero
	input  logic [87:0] s_axis_tdata,
	// [0] block_end
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] dot_result
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import tcbdp_pkg::*;

	localparam int SUM_W  = $clog2(256 * BLOCK_VALUES) + 1;
	localparam int SUM_HI = 256 * BLOCK_VALUES - 1;
	localparam int SUM_LO = -256 * BLOCK_VALUES;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LANE = 3'd1;
	localparam logic [2:0] S_CVH  = 3'd2;
	localparam logic [2:0] S_MUL1 = 3'd3;
	localparam logic [2:0] S_CVI  = 3'd4;
	localparam logic [2:0] S_MUL2 = 3'd5;
	localparam logic [2:0] S_ADD  = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0]              state_q;
	logic [1:0]              lane_q;
	logic [63:0]             cb_q [4];
	logic [7:0]              pattern_q;
	logic signed [7:0]       act_q [4];
	logic [15:0]             wsh_q;
	logic [31:0]             asc_q;
	logic                    blk_end_q, row_end_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [31:0]             acc_q, scale_q, tmp_q;
	logic                    pend_q;

	logic [4:0]              cb_idx;
	logic [1:0]              q_sel;
	logic signed [SUM_W:0]   term, sum_next;
	logic signed [SUM_W-1:0] sum_sat;
	logic                    fp_state;
	fpu_req_t                fpu_req;
	fpu_stat_t               fpu_stat;
	logic [31:0]             fpu_a, fpu_b, fpu_res;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign cb_idx        = s_axis_tdata[4:0];

	// per-lane term (q-1)*act, then saturating accumulate
	always_comb begin
		q_sel = pattern_q[2*lane_q +: 2];
		unique case (q_sel)
			2'd0:    term = -(SUM_W+1)'(act_q[lane_q]);
			2'd1:    term = '0;
			2'd2:    term = (SUM_W+1)'(act_q[lane_q]);
			default: term = (SUM_W+1)'(act_q[lane_q]) <<< 1;
		endcase
		sum_next = (SUM_W+1)'(sum_q) + term;
		if (sum_next > (SUM_W+1)'(SUM_HI)) sum_sat = SUM_W'(SUM_HI);
		else if (sum_next < (SUM_W+1)'(SUM_LO)) sum_sat = SUM_W'(SUM_LO);
		else sum_sat = sum_next[SUM_W-1:0];
	end

	always_comb begin
		fp_state = (state_q == S_CVH) || (state_q == S_MUL1) || (state_q == S_CVI) ||
		           (state_q == S_MUL2) || (state_q == S_ADD);
		fpu_req.start = fp_state && !fpu_stat.busy && !pend_q;
		fpu_a = tmp_q;
		fpu_b = tmp_q;
		fpu_req.op = FOP_ADD;
		unique case (state_q)
			S_CVH: begin
				fpu_req.op = FOP_CVH;
				fpu_a      = {16'd0, wsh_q};
			end
			S_MUL1: begin
				fpu_req.op = FOP_MUL;
				fpu_b      = asc_q;
			end
			S_CVI: begin
				fpu_req.op = FOP_CVI;
				fpu_a      = {{(32-SUM_W){sum_q[SUM_W-1]}}, sum_q};
			end
			S_MUL2: begin
				fpu_req.op = FOP_MUL;
				fpu_b      = scale_q;
			end
			S_ADD: begin
				fpu_req.op = FOP_ADD;
				fpu_a      = acc_q;
			end
			default: ;
		endcase
	end

	tcbdp_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.a      (fpu_a),
		.b      (fpu_b),
		.stat   (fpu_stat),
		.result (fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			lane_q        <= '0;
			sum_q         <= '0;
			acc_q         <= '0;
			pend_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < 4; i++) cb_q[i] <= '0;
		end else begin
			if (cfg_valid) cb_q[cfg_index] <= cfg_data;
			if (m_axis_tready && (state_q != S_EMIT)) m_axis_tvalid <= 1'b0;
			if (fpu_req.start) pend_q <= 1'b1;
			if (fpu_stat.done) pend_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						pattern_q <= cb_q[cb_idx[4:3]][8*cb_idx[2:0] +: 8];
						act_q[0]  <= s_axis_tdata[12:5];
						act_q[1]  <= s_axis_tdata[20:13];
						act_q[2]  <= s_axis_tdata[28:21];
						act_q[3]  <= s_axis_tdata[36:29];
						wsh_q     <= s_axis_tdata[52:37];
						asc_q     <= s_axis_tdata[84:53];
						blk_end_q <= s_axis_tuser | s_axis_tlast;
						row_end_q <= s_axis_tlast;
						lane_q    <= '0;
						state_q   <= S_LANE;
					end
				end
				S_LANE: begin
					sum_q  <= sum_sat;
					lane_q <= lane_q + 2'd1;
					if (lane_q == 2'd3) state_q <= blk_end_q ? S_CVH : S_IDLE;
				end
				S_CVH: if (fpu_stat.done) begin
					tmp_q   <= fpu_res;
					state_q <= S_MUL1;
				end
				S_MUL1: if (fpu_stat.done) begin
					scale_q <= fpu_res;
					state_q <= S_CVI;
				end
				S_CVI: if (fpu_stat.done) begin
					tmp_q   <= fpu_res;
					sum_q   <= '0;
					state_q <= S_MUL2;
				end
				S_MUL2: if (fpu_stat.done) begin
					tmp_q   <= fpu_res;
					state_q <= S_ADD;
				end
				S_ADD: if (fpu_stat.done) begin
					acc_q   <= fpu_res;
					state_q <= row_end_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tdata  <= acc_q;
						m_axis_tvalid <= 1'b1;
						acc_q         <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_stat.done |-> pend_q) else $error("float result without request");
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_EMIT)) else $error("stray result");
	a_fp_only_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_req.start |-> blk_end_q) else $error("float work outside block end");
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL2) && $past(state_q == S_CVI) |-> (sum_q == '0))
		else $error("block sum not cleared");

endmodule
